@@ rtl/lslp_pkg.sv @@
// shared constants and types for the least-squares line predictor
// used by every module of the block; no dependencies
package lslp_pkg;

  localparam int MAX_POINTS      = 64;
  localparam int TIME_DELTA_BITS = 28;
  localparam int CNT_W           = 7;
  localparam int WW              = 128;   // width of the serial datapath
  localparam int WCNT_W          = $clog2(WW);
  localparam int PAISE_W         = 48;
  localparam logic [15:0] RATE_RESET = 16'd7527;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_PREDICT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOFIT = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_BASE_TIME = 1'b0,
    REG_RATE      = 1'b1
  } reg_idx_t;

  // handshake between sequencer and a serial unit
  typedef struct packed {
    logic go;
    logic done;
  } unit_ctl_t;

endpackage

@@ rtl/lslp_mul.sv @@
// shift-and-add multiplier, one multiplier bit per cycle
// depends on lslp_pkg
module lslp_mul import lslp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [WW-1:0] mul_a,
  input  logic [WW-1:0] mul_b,
  output logic          done,
  output logic [WW-1:0] prod
);

  logic          busy_r;
  logic [WW-1:0] mc_r;
  logic [WW-1:0] ml_r;
  logic [WW-1:0] acc_r;

  // finishes as soon as the multiplier runs out of set bits
  assign done = busy_r && (ml_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      mc_r  <= mul_a;
      ml_r  <= mul_b;
      acc_r <= '0;
    end else if (busy_r && ml_r != '0) begin
      if (ml_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= {mc_r[WW-2:0], 1'b0};
      ml_r <= {1'b0, ml_r[WW-1:1]};
    end
  end

endmodule

@@ rtl/lslp_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on lslp_pkg
module lslp_div import lslp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [WW-1:0] dividend,
  input  logic [WW-1:0] divisor,
  output logic          done,
  output logic [WW-1:0] quot
);

  logic              busy_r;
  logic              done_r;
  logic [WCNT_W-1:0] cnt_r;
  logic [WW-1:0]     dvd_r;
  logic [WW-1:0]     dsr_r;
  logic [WW-1:0]     rem_r;
  logic [WW-1:0]     rem_sh;
  logic              ge;

  assign rem_sh = {rem_r[WW-2:0], dvd_r[WW-1]};
  assign ge     = rem_sh >= dsr_r;
  assign done   = done_r;
  assign quot   = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= WCNT_W'(WW - 1);
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - dsr_r : rem_sh;
      dvd_r <= {dvd_r[WW-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ rtl/least_squares_line_predictor_unit.sv @@
// least-squares line predictor: sums, command handling and predict sequencer
// depends on lslp_pkg, lslp_mul, lslp_div
// clear, unused and rejected items: result in the cycle after accept
// add point: sums update in S_ADDP, which then registers the result
// predict: ten serial multiplies (one multiplier bit per cycle), stopping after the
// second with no fit, else then a divide; the result is registered from S_FIN
// one item at a time; reset (rst_n low, synchronous) clears sums, count and base time and sets rate to RATE_RESET
module least_squares_line_predictor_unit import lslp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // command[1:0], time_sec[33:2], price_cents[57:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // status[1:0], predicted_paise[49:2], points_held[56:50]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADDP = 5'b00010,
    S_MULW = 5'b00100,
    S_DIVW = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    K_NSXX = 4'd0, K_SXSX = 4'd1, K_NSXY = 4'd2, K_SXSY = 4'd3, K_NT = 4'd4,
    K_SYD  = 4'd5, K_NP   = 4'd6, K_RATE = 4'd7, K_ND   = 4'd8, K_D100 = 4'd9
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [31:0]      base_r;
  logic [15:0]      rate_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [33:0]      sx_r, sx_nxt;
  logic [29:0]      sy_r, sy_nxt;
  logic [61:0]      sxx_r, sxx_nxt;
  logic [57:0]      sxy_r, sxy_nxt;

  logic [TIME_DELTA_BITS-1:0] dlt_r, dlt_nxt;
  logic [23:0]                prc_r, prc_nxt;

  logic [WW-1:0] t_r, t_nxt, d_r, d_nxt, nn_r, nn_nxt, p_r, p_nxt;
  logic [WW-1:0] num_r, num_nxt, den_r, den_nxt;
  logic          nneg_r, nneg_nxt, pneg_r, pneg_nxt, sgn_r, sgn_nxt;

  logic                    ov_r, ov_nxt;
  status_t                 ost_r, ost_nxt;
  logic [PAISE_W-1:0]      opz_r, opz_nxt, rpz_r, rpz_nxt;
  logic [CNT_W-1:0]        opt_r, opt_nxt;
  status_t                 rst_r, rst_nxt;

  unit_ctl_t     mul_c, div_c;
  logic          mgo_r, mgo_nxt, dgo_r, dgo_nxt;
  logic [WW-1:0] mul_a, mul_b, mul_p, div_q;

  cmd_t               cmd;
  logic [31:0]        tin;
  logic [23:0]        pin;
  logic [32:0]        tdiff;
  logic               in_rng, acc, out_free;
  logic [WW-1:0]      lim, sub_td;
  logic [PAISE_W-1:0] mag;
  logic [55:0]        sq, tp;

  assign cmd    = cmd_t'(in_tdata[1:0]);
  assign tin    = in_tdata[33:2];
  assign pin    = in_tdata[57:34];
  assign tdiff  = {1'b0, tin} - {1'b0, base_r};
  assign in_rng = !tdiff[32] && (tdiff[31:TIME_DELTA_BITS] == '0);

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, opt_r, opz_r, ost_r};

  assign mul_c.go = mgo_r;
  assign div_c.go = dgo_r;

  assign sq = 56'(dlt_r) * 56'(dlt_r);
  assign tp = 56'(dlt_r) * 56'(prc_r);

  assign sub_td = t_r - mul_p;
  assign lim    = sgn_r ? WW'(64'h8000_0000_0000) : WW'(64'h7FFF_FFFF_FFFF);
  assign mag    = (div_q > lim) ? lim[PAISE_W-1:0] : div_q[PAISE_W-1:0];

  lslp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_c.go),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .done  (mul_c.done),
    .prod  (mul_p)
  );

  lslp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_c.go),
    .dividend ({num_r[WW-2:0], 1'b0} + den_r),
    .divisor  ({den_r[WW-2:0], 1'b0}),
    .done     (div_c.done),
    .quot     (div_q)
  );

  // operands of each multiply; the narrow one goes on the serial side
  always_comb begin
    case (step_r)
      K_NSXX:  begin mul_a = WW'(sxx_r); mul_b = WW'(cnt_r); end
      K_SXSX:  begin mul_a = WW'(sx_r);  mul_b = WW'(sx_r);  end
      K_NSXY:  begin mul_a = WW'(sxy_r); mul_b = WW'(cnt_r); end
      K_SXSY:  begin mul_a = WW'(sx_r);  mul_b = WW'(sy_r);  end
      K_NT:    begin mul_a = WW'(dlt_r); mul_b = WW'(cnt_r); end
      K_SYD:   begin mul_a = d_r;        mul_b = WW'(sy_r);  end
      K_NP:    begin mul_a = nn_r;       mul_b = p_r;        end
      K_RATE:  begin mul_a = num_r;      mul_b = WW'(rate_r); end
      K_ND:    begin mul_a = d_r;        mul_b = WW'(cnt_r); end
      K_D100:  begin mul_a = den_r;      mul_b = WW'(7'd100); end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt = cnt_r; sx_nxt = sx_r; sy_nxt = sy_r; sxx_nxt = sxx_r; sxy_nxt = sxy_r;
    dlt_nxt = dlt_r; prc_nxt = prc_r;
    t_nxt = t_r; d_nxt = d_r; nn_nxt = nn_r; p_nxt = p_r;
    num_nxt = num_r; den_nxt = den_r;
    nneg_nxt = nneg_r; pneg_nxt = pneg_r; sgn_nxt = sgn_r;
    rst_nxt = rst_r; rpz_nxt = rpz_r;
    mgo_nxt = 1'b0;
    dgo_nxt = 1'b0;
    ov_nxt  = ov_r && !out_tready;
    ost_nxt = ost_r; opz_nxt = opz_r; opt_nxt = opt_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          dlt_nxt = tdiff[TIME_DELTA_BITS-1:0];
          prc_nxt = pin;
          ov_nxt  = 1'b1;
          ost_nxt = ST_OK;
          opz_nxt = '0;
          opt_nxt = cnt_r;
          case (cmd)
            CMD_CLEAR: begin
              cnt_nxt = '0; sx_nxt = '0; sy_nxt = '0; sxx_nxt = '0; sxy_nxt = '0;
              opt_nxt = '0;
            end
            CMD_ADD: begin
              if (!in_rng) begin
                ost_nxt = ST_RANGE;
              end else if (cnt_r >= CNT_W'(MAX_POINTS)) begin
                ost_nxt = ST_FULL;
              end else begin
                ov_nxt    = ov_r && !out_tready;
                state_nxt = S_ADDP;
              end
            end
            CMD_PREDICT: begin
              if (!in_rng) begin
                ost_nxt = ST_RANGE;
              end else begin
                ov_nxt    = ov_r && !out_tready;
                step_nxt  = K_NSXX;
                mgo_nxt   = 1'b1;
                state_nxt = S_MULW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADDP: begin
        if (out_free) begin
          cnt_nxt = cnt_r + 1'b1;
          sx_nxt  = sx_r + 34'(dlt_r);
          sy_nxt  = sy_r + 30'(prc_r);
          sxx_nxt = sxx_r + 62'(sq);
          sxy_nxt = sxy_r + 58'(tp);
          ov_nxt  = 1'b1;
          ost_nxt = ST_OK;
          opz_nxt = '0;
          opt_nxt = cnt_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MULW: begin
        if (mul_c.done) begin
          mgo_nxt  = 1'b1;
          step_nxt = step_t'(step_r + 1'b1);
          case (step_r)
            K_NSXX: t_nxt = mul_p;
            K_SXSX: begin
              d_nxt = (t_r >= mul_p) ? sub_td : '0;
              if (t_r <= mul_p) begin
                // no spread in time: no line to fit
                mgo_nxt   = 1'b0;
                rst_nxt   = ST_NOFIT;
                rpz_nxt   = '0;
                state_nxt = S_FIN;
              end
            end
            K_NSXY: t_nxt = mul_p;
            K_SXSY: begin
              nneg_nxt = t_r < mul_p;
              nn_nxt   = (t_r < mul_p) ? mul_p - t_r : sub_td;
            end
            K_NT: begin
              pneg_nxt = mul_p < WW'(sx_r);
              p_nxt    = pneg_nxt ? WW'(sx_r) - mul_p : mul_p - WW'(sx_r);
            end
            K_SYD: t_nxt = mul_p;
            K_NP: begin
              if (nneg_r != pneg_r) begin
                sgn_nxt = t_r < mul_p;
                num_nxt = (t_r < mul_p) ? mul_p - t_r : sub_td;
              end else begin
                sgn_nxt = 1'b0;
                num_nxt = t_r + mul_p;
              end
            end
            K_RATE: num_nxt = mul_p;
            K_ND:   den_nxt = mul_p;
            K_D100: begin
              den_nxt   = mul_p;
              mgo_nxt   = 1'b0;
              dgo_nxt   = 1'b1;
              state_nxt = S_DIVW;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIVW: begin
        if (div_c.done) begin
          rst_nxt   = ST_OK;
          rpz_nxt   = sgn_r ? PAISE_W'(0) - mag : mag;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = rst_r;
          opz_nxt   = rpz_r;
          opt_nxt   = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= K_NSXX;
      base_r  <= '0;
      rate_r  <= RATE_RESET;
      cnt_r   <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      sxy_r   <= '0;
      ov_r    <= 1'b0;
      mgo_r   <= 1'b0;
      dgo_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sxx_r   <= sxx_nxt;
      sxy_r   <= sxy_nxt;
      ov_r    <= ov_nxt;
      mgo_r   <= mgo_nxt;
      dgo_r   <= dgo_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_BASE_TIME: base_r <= cfg_wdata;
          REG_RATE:      rate_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dlt_r <= dlt_nxt; prc_r <= prc_nxt;
    t_r <= t_nxt; d_r <= d_nxt; nn_r <= nn_nxt; p_r <= p_nxt;
    num_r <= num_nxt; den_r <= den_nxt;
    nneg_r <= nneg_nxt; pneg_r <= pneg_nxt; sgn_r <= sgn_nxt;
    rst_r <= rst_nxt; rpz_r <= rpz_nxt;
    ost_r <= ost_nxt; opz_r <= opz_nxt; opt_r <= opt_nxt;
  end

endmodule

@@ rtl/lslp_checker.sv @@
// port-level checks for the least-squares line predictor, bound to the top
// depends on lslp_pkg and least_squares_line_predictor_unit
module lslp_checker import lslp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a held result does not change
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[56:50] <= CNT_W'(MAX_POINTS))
    else $error("points held beyond store size");

  // any failure status carries a zero prediction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[49:2] == '0)
    else $error("nonzero prediction with failure status");

  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind least_squares_line_predictor_unit lslp_checker u_lslp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ sim/least_squares_line_predictor_checker.sv @@
// checker for the least-squares line predictor: watches the item and config ports,
// keeps its own copy of the sums and registers, and compares every result item
// depends on lslp_pkg
module least_squares_line_predictor_checker import lslp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          results_owed
);

  typedef struct packed {
    status_t     status;
    logic [47:0] paise;
    logic [6:0]  held;
  } line_result_t;

  line_result_t owed_q[$];

  logic [31:0] base_time;
  logic [15:0] rate;
  logic [6:0]  n_pts;
  logic [63:0] s_t, s_p, s_tt, s_tp;

  assign results_owed = owed_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // evaluate the fitted line at delta time tq, in paise
  function automatic status_t fit_line(input logic [63:0] tq, output logic [47:0] paise);
    logic [255:0] n, sx, sy, a, b, d, nn, p, num, den, q, lim;
    logic         nneg, pneg;
    logic [63:0]  mag;
    n  = 256'(n_pts);
    sx = 256'(s_t);
    sy = 256'(s_p);
    paise = '0;
    a = n * 256'(s_tt);
    b = sx * sx;
    d = (a >= b) ? a - b : '0;
    if (d == 0) return ST_NOFIT;
    a = n * 256'(s_tp);
    b = sx * sy;
    nneg = a < b;
    nn = nneg ? b - a : a - b;
    a = n * 256'(tq);
    pneg = a < sx;
    p = pneg ? sx - a : a - sx;
    a = sy * d;
    b = nn * p;
    if (nneg != pneg) begin
      nneg = a < b;
      num = nneg ? b - a : a - b;
    end else begin
      num = a + b;
      nneg = 1'b0;
    end
    // round half away from zero: (2*num*rate + den) / (2*den)
    num = num * 256'(rate);
    den = n * d * 256'd100;
    q = (2 * num + den) / (2 * den);
    lim = nneg ? 256'(64'd1 << 47) : 256'((64'd1 << 47) - 1);
    mag = (q > lim) ? lim[63:0] : q[63:0];
    if (nneg) mag = 64'd0 - mag;
    paise = mag[47:0];
    return ST_OK;
  endfunction

  function automatic line_result_t apply_item(input logic [63:0] item);
    line_result_t r;
    cmd_t         cmd;
    logic [63:0]  t, price, delta;
    logic         in_range;
    cmd   = cmd_t'(item[1:0]);
    t     = 64'(item[33:2]);
    price = 64'(item[57:34]);
    in_range = (t >= 64'(base_time)) && ((t - 64'(base_time)) < (64'd1 << TIME_DELTA_BITS));
    delta = t - 64'(base_time);
    r.status = ST_OK;
    r.paise  = '0;
    case (cmd)
      CMD_CLEAR: begin
        n_pts = '0; s_t = '0; s_p = '0; s_tt = '0; s_tp = '0;
      end
      CMD_ADD: begin
        if (!in_range) r.status = ST_RANGE;
        else if (n_pts >= MAX_POINTS) r.status = ST_FULL;
        else begin
          n_pts++;
          s_t  += delta;
          s_p  += price;
          s_tt += delta * delta;
          s_tp += delta * price;
        end
      end
      CMD_PREDICT: begin
        if (!in_range) r.status = ST_RANGE;
        else r.status = fit_line(delta, r.paise);
        if (r.status != ST_OK) r.paise = '0;
      end
      default: ;
    endcase
    r.held = n_pts;
    return r;
  endfunction

  always @(posedge clk) begin
    line_result_t want;
    if (!rst_n) begin
      base_time  <= '0;
      rate       <= RATE_RESET;
      n_pts      = '0;
      s_t        = '0; s_p = '0; s_tt = '0; s_tp = '0;
      fail_count = 0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        if (reg_idx_t'(cfg_addr) == REG_BASE_TIME) base_time <= cfg_wdata;
        else rate <= cfg_wdata[15:0];
      end
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          report("unexpected item", out_tdata, '0);
        end else begin
          want = owed_q.pop_front();
          if (out_tdata[1:0] != want.status) report("status", out_tdata[1:0], want.status);
          if (out_tdata[49:2] != want.paise) report("paise", out_tdata[49:2], want.paise);
          if (out_tdata[56:50] != want.held) report("points", out_tdata[56:50], want.held);
        end
      end
      if (in_tvalid && in_tready) owed_q.push_back(apply_item(in_tdata));
    end
  end

endmodule

@@ sim/least_squares_line_predictor_unit_tb.sv @@
// testbench top for the least-squares line predictor: clock, reset, stimulus, verdict
// depends on lslp_pkg, the block and least_squares_line_predictor_checker
module least_squares_line_predictor_unit_tb;
  import lslp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [31:0] DELTA_MAX = (32'd1 << TIME_DELTA_BITS) - 1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // command[1:0], time_sec[33:2], price_cents[57:34]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // status[1:0], predicted_paise[49:2], points_held[56:50]
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          results_owed;
  int          snd_idle, rcv_idle;
  int          cycles;
  logic [31:0] base_now;

  least_squares_line_predictor_unit dut (.*);

  least_squares_line_predictor_checker checker_i (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    snd_idle = 0; rcv_idle = 0; cycles = 0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(input cmd_t cmd, input logic [31:0] t, input logic [23:0] price);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, price, t, cmd};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_BASE_TIME) base_now = val;
  endtask

  // in-range points most of the time, a quarter of them near the base, noise otherwise
  task automatic random_items(input int count);
    int          pick;
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) t = base_now + $urandom_range(0, 63);
      else t = base_now + ($urandom & DELTA_MAX);
      if (pick < 5) send(CMD_CLEAR, $urandom, 24'($urandom));
      else if (pick < 60) send(CMD_ADD, t, 24'($urandom));
      else if (pick < 88) send(CMD_PREDICT, t, 24'($urandom));
      else if (pick < 91) send(CMD_NONE, $urandom, 24'($urandom));
      else if (pick < 96) send(CMD_ADD, $urandom, 24'($urandom));
      else send(CMD_PREDICT, $urandom, 24'($urandom));
      if ($urandom_range(0, 299) == 0) drain();
    end
  endtask

  initial begin
    base_now = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, extremes, range errors, unused command
    send(CMD_PREDICT, 32'd0, 24'd0);
    send(CMD_ADD, 32'd0, 24'd0);
    send(CMD_ADD, DELTA_MAX, 24'hFFFFFF);
    send(CMD_PREDICT, 32'd0, 24'd0);
    send(CMD_PREDICT, DELTA_MAX, 24'd0);
    send(CMD_ADD, DELTA_MAX + 1, 24'd5);
    send(CMD_PREDICT, 32'hFFFFFFFF, 24'd0);
    send(CMD_NONE, 32'hFFFFFFFF, 24'hFFFFFF);
    // same time twice gives no fit
    send(CMD_CLEAR, 32'd0, 24'd0);
    send(CMD_ADD, 32'd7, 24'd100);
    send(CMD_ADD, 32'd7, 24'd900);
    send(CMD_PREDICT, 32'd7, 24'd0);
    // fill the store past full, then one more add
    for (int i = 0; i < MAX_POINTS; i++) send(CMD_ADD, DELTA_MAX - 32'(i), 24'($urandom));
    send(CMD_ADD, 32'd3, 24'd3);
    send(CMD_PREDICT, 32'd0, 24'd0);
    drain();

    // positive and negative saturation at the largest rate
    write_reg(REG_RATE, 32'd65535);
    send(CMD_CLEAR, 32'd0, 24'd0);
    send(CMD_ADD, 32'd0, 24'd0);
    send(CMD_ADD, 32'd1, 24'hFFFFFF);
    send(CMD_PREDICT, DELTA_MAX, 24'd0);
    send(CMD_CLEAR, 32'd0, 24'd0);
    send(CMD_ADD, 32'd0, 24'hFFFFFF);
    send(CMD_ADD, 32'd1, 24'd0);
    send(CMD_PREDICT, DELTA_MAX, 24'd0);
    drain();
    // zero rate, and times below the base
    write_reg(REG_RATE, 32'd0);
    write_reg(REG_BASE_TIME, 32'd100);
    send(CMD_ADD, 32'd5, 24'd1);
    send(CMD_PREDICT, 32'd100, 24'd0);
    drain();
    write_reg(REG_BASE_TIME, 32'hFFFFFFFF);
    write_reg(REG_RATE, 32'd7527);
    send(CMD_CLEAR, 32'd0, 24'd0);
    send(CMD_ADD, 32'hFFFFFFFF, 24'd50);
    send(CMD_PREDICT, 32'hFFFFFFFE, 24'd0);
    send(CMD_PREDICT, 32'hFFFFFFFF, 24'd0);
    drain();

    snd_idle = 31; rcv_idle = 82;
    write_reg(REG_BASE_TIME, $urandom);
    random_items(250);
    drain();
    write_reg(REG_RATE, 32'd65535);
    random_items(250);
    drain();

    snd_idle = 82; rcv_idle = 31;
    write_reg(REG_BASE_TIME, 32'd0);
    write_reg(REG_RATE, 32'd1);
    random_items(250);
    drain();
    write_reg(REG_RATE, $urandom_range(0, 65535));
    random_items(250);
    drain();

    snd_idle = 0; rcv_idle = 0;
    write_reg(REG_BASE_TIME, 32'hF0000000 + $urandom_range(0, 65535));
    write_reg(REG_RATE, 32'd7527);
    random_items(370);
    drain();
    write_reg(REG_RATE, 32'd0);
    random_items(60);
    drain();
    write_reg(REG_BASE_TIME, 32'hFFFFFFFF);
    random_items(30);

    drain();
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
